// ===== rtl/fau_pkg.sv =====
// fau_pkg: shared types and codes for the fraction arithmetic unit
`timescale 1ns / 1ps
`default_nettype none

package fau_pkg;

  // operation codes carried by the command field
  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  // sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL,
    ST_CHECK,
    ST_GCD,
    ST_DIVN,
    ST_DIVD
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/fau_divider.sv =====
// fau_divider: unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module fau_divider #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WIDTH-1:0] dividend_i,
  input  wire logic [WIDTH-1:0] divisor_i,
  output logic      [WIDTH-1:0] quotient_o,
  output logic                  done_o
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             fits;

  // trial subtraction of the shifted partial remainder
  assign trial = {rem_q, quo_q[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = !diff[WIDTH];

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(WIDTH - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  // datapath flops
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    cnt_q <= cnt_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

// ===== rtl/fraction_arithmetic_unit.sv =====
// fraction_arithmetic_unit: sequenced rational add, subtract, multiply and divide
`timescale 1ns / 1ps
`default_nettype none

// Usage: drive command_i and the four operand ports and raise start while busy
// is low; the beat is taken at that clock edge and busy goes high next cycle.
// The result appears on result_numerator_o, result_denominator_o and
// zero_denominator_o for exactly one cycle, marked by done_o; the receiver
// cannot stall it, so it must take the beat in that cycle. Ports hold the
// last result afterwards. busy drops in the strobe cycle, so a new start may
// be given then.
// Subtract, multiply, divide, an add giving zero numerator, and any zero
// denominator end at the check state. One signed multiplier is used three
// times in turn, then the sum is formed and the checks are made. A reduced
// add then runs a binary GCD loop (one compare and subtract or shift per
// cycle on the two magnitudes, MW = 2*OPERAND_WIDTH bits each) and two
// restoring divisions by the GCD, of the numerator and the denominator.
// One item is in flight at a time. Reset clears the sequencer and the strobe.
module fraction_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      command_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_numerator_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_denominator_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_numerator_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_denominator_i,
  output logic signed [31:0]                   result_numerator_o,
  output logic signed [31:0]                   result_denominator_o,
  output logic                                 zero_denominator_o,
  output logic                                 done_o
);

  import fau_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * W;
  localparam int SW = MW + 1;
  localparam int XW = (SW > 32) ? SW : 32;
  localparam int KW = $clog2(MW + 1);

  state_e              state_q, state_d;
  cmd_e                cmd_q, cmd_d;
  logic signed [W-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic [1:0]          step_q, step_d;
  logic signed [MW-1:0] p1_q, p1_d, p2_q, p2_d, p3_q, p3_d;
  logic signed [SW-1:0] num_q, num_d, den_q, den_d;
  logic [MW-1:0]       u_q, u_d, v_q, v_d, g_q, g_d, qn_q, qn_d;
  logic [KW-1:0]       k_q, k_d;
  logic signed [31:0]  res_num_q, res_num_d, res_den_q, res_den_d;
  logic                flag_q, flag_d;
  logic                done_q, done_d;

  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [MW-1:0] product;
  logic signed [SW-1:0] neg_num, neg_den, qn_pos, qd_pos;
  logic [MW-1:0]        mag_num, mag_den, gcd_val;
  logic signed [SW-1:0] fin_num, fin_den;
  logic signed [XW-1:0] ext_num, ext_den;
  logic                 fin_flag, finish;
  logic                 div_start, div_done;
  logic [MW-1:0]        div_dividend, div_divisor, div_quo;

  // shared multiplier, operands picked by step
  always_comb begin
    mul_a = ad_q;
    mul_b = bd_q;
    case (step_q)
      2'd0: begin
        mul_a = an_q;
        mul_b = (cmd_q == CMD_MUL) ? bn_q : bd_q;
      end
      2'd1: begin
        mul_b = bn_q;
      end
      default: begin
        mul_b = bd_q;
      end
    endcase
  end
  assign product = MW'(mul_a) * MW'(mul_b);

  // magnitudes and signed reduced values
  assign neg_num = -num_q;
  assign neg_den = -den_q;
  assign mag_num = num_q[SW-1] ? neg_num[MW-1:0] : num_q[MW-1:0];
  assign mag_den = den_q[SW-1] ? neg_den[MW-1:0] : den_q[MW-1:0];
  assign gcd_val = u_q << k_q;
  assign qn_pos  = $signed({1'b0, qn_q});
  assign qd_pos  = $signed({1'b0, div_quo});

  // divider operand selection
  assign div_dividend = (state_q == ST_DIVN) ? mag_den : mag_num;
  assign div_divisor  = (state_q == ST_GCD) ? gcd_val : g_q;

  fau_divider #(
    .WIDTH (MW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  // sequencer: next state and datapath updates
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    an_d      = an_q;
    ad_d      = ad_q;
    bn_d      = bn_q;
    bd_d      = bd_q;
    step_d    = step_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    p3_d      = p3_q;
    num_d     = num_q;
    den_d     = den_q;
    u_d       = u_q;
    v_d       = v_q;
    k_d       = k_q;
    g_d       = g_q;
    qn_d      = qn_q;
    div_start = 1'b0;
    finish    = 1'b0;
    fin_num   = num_q;
    fin_den   = den_q;
    fin_flag  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d   = cmd_e'(command_i);
          an_d    = a_numerator_i;
          ad_d    = a_denominator_i;
          bn_d    = b_numerator_i;
          bd_d    = b_denominator_i;
          step_d  = 2'd0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        case (step_q)
          2'd0:    p1_d = product;
          2'd1:    p2_d = product;
          default: p3_d = product;
        endcase
        if (step_q == 2'd2) begin
          state_d = ST_EVAL;
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      ST_EVAL: begin
        case (cmd_q)
          CMD_ADD: num_d = SW'(p1_q) + SW'(p2_q);
          CMD_SUB: num_d = SW'(p1_q) - SW'(p2_q);
          default: num_d = SW'(p1_q);
        endcase
        den_d   = (cmd_q == CMD_DIV) ? SW'(p2_q) : SW'(p3_q);
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (den_q == '0) begin
          finish   = 1'b1;
          fin_flag = 1'b1;
        end else if (cmd_q != CMD_ADD) begin
          finish = 1'b1;
        end else if (num_q == '0) begin
          finish  = 1'b1;
          fin_den = SW'(1);
        end else begin
          u_d     = mag_num;
          v_d     = mag_den;
          k_d     = '0;
          state_d = ST_GCD;
        end
      end
      ST_GCD: begin
        // binary gcd: one shift or subtract per cycle
        if (u_q == v_q) begin
          g_d       = gcd_val;
          div_start = 1'b1;
          state_d   = ST_DIVN;
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (u_q > v_q) begin
          u_d = u_q - v_q;
        end else begin
          v_d = v_q - u_q;
        end
      end
      ST_DIVN: begin
        if (div_done) begin
          qn_d      = div_quo;
          div_start = 1'b1;
          state_d   = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (div_done) begin
          finish  = 1'b1;
          fin_num = num_q[SW-1] ? -qn_pos : qn_pos;
          fin_den = den_q[SW-1] ? -qd_pos : qd_pos;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (finish) begin
      state_d = ST_IDLE;
    end
  end

  // result register load
  assign ext_num = XW'(fin_num);
  assign ext_den = XW'(fin_den);

  always_comb begin
    res_num_d = res_num_q;
    res_den_d = res_den_q;
    flag_d    = flag_q;
    done_d    = finish;
    if (finish) begin
      res_num_d = ext_num[31:0];
      res_den_d = ext_den[31:0];
      flag_d    = fin_flag;
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    an_q      <= an_d;
    ad_q      <= ad_d;
    bn_q      <= bn_d;
    bd_q      <= bd_d;
    step_q    <= step_d;
    p1_q      <= p1_d;
    p2_q      <= p2_d;
    p3_q      <= p3_d;
    num_q     <= num_d;
    den_q     <= den_d;
    u_q       <= u_d;
    v_q       <= v_d;
    k_q       <= k_d;
    g_q       <= g_d;
    qn_q      <= qn_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    flag_q    <= flag_d;
  end

  assign busy                 = (state_q != ST_IDLE);
  assign result_numerator_o   = res_num_q;
  assign result_denominator_o = res_den_q;
  assign zero_denominator_o   = flag_q;
  assign done_o               = done_q;

`ifndef SYNTH
  // an accepted beat always makes the unit busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // the strobe only comes once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // a flagged result always carries a zero denominator
  a_flag_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && zero_denominator_o |-> result_denominator_o == 32'sd0)
    else $error("zero denominator flag with nonzero denominator");

  // the divider only finishes while the sequencer waits for it
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVN || state_q == ST_DIVD))
    else $error("divider finished outside a divide state");
`endif

endmodule

`default_nettype wire
